// ----- hdl/fr90_pkg.sv -----
// Package for the frame rotation engine: codes, shared types and default sizes.
// Used by every module of the block; depends on nothing.
package fr90_pkg;

    localparam int PIX_W          = 24;
    localparam int CFG_DATA_W     = 11;
    localparam int CFG_INDEX_W    = 2;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DIM_RESET      = 1024;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_ROTATION = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT   = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    typedef enum logic [1:0] {
        ROT_NONE,
        ROT_90,
        ROT_180,
        ROT_270
    } rot_t;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_EARLY
    } op_t;

    typedef struct packed {
        op_t  op;
        logic last;
    } fr90_ctl_t;

endpackage

// ----- hdl/frame_rotate_90_multiple_top.sv -----
// Top level of the frame rotation engine (0, 90, 180, 270 degrees).
// Instantiates fr90_front, fr90_fifo and fr90_back; depends on fr90_pkg.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_tvalid/tready    tdata = pixel_in, tuser = cmd
//   m_        out        m_tvalid/tready    tdata = pixel_out, tlast = last, tuser = early
//   cfg_      in         cfg_wr_en          cfg_index, cfg_wdata
//
// The front accepts one input transfer per cycle while the queue
// has room. The frame store has one port, used once per cycle for a write or a read.
// After its emit transfer, a result passes through the queue, the s1 and s2 registers and the output register.
// Output stalls hold the back part; the queue then fills and lowers s_tready.
// Reset is synchronous and active low; the frame store has no clearing pass.
module frame_rotate_90_multiple_top import fr90_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [PIX_W-1:0]        s_tdata,    // [23:0] pixel_in
    input  logic                    s_tuser,    // [0] cmd
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [PIX_W-1:0]        m_tdata,    // [23:0] pixel_out
    output logic                    m_tlast,
    output logic                    m_tuser,    // [0] early
    input  logic                    cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int MAXD    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DW      = $clog2(MAXD + 1);
    localparam int PW      = $clog2(MAXD);
    localparam int AW      = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int ENTRY_W = $bits(fr90_ctl_t) + PIX_W + AW + 2 * PW;

    logic               q_push, q_pop, q_full, q_empty;
    logic [ENTRY_W-1:0] q_push_data, q_pop_data;
    logic [DW-1:0]      dim_w;

    fr90_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DW         (DW),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_data (q_push_data),
        .dim_w       (dim_w)
    );

    fr90_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    fr90_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DW         (DW),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_pop_data (q_pop_data),
        .q_pop      (q_pop),
        .dim_w      (dim_w),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

// ----- hdl/fr90_front.sv -----
// Front part of the frame rotation engine: configuration registers, load and output
// raster counters, and classification of each input transfer into a queue entry.
// Depends on fr90_pkg.
module fr90_front import fr90_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int DW         = 11,
    parameter int ENTRY_W    = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [PIX_W-1:0]        s_tdata,
    input  logic                    s_tuser,
    input  logic                    cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                    q_full,
    output logic                    q_push,
    output logic [ENTRY_W-1:0]      q_push_data,
    output logic [DW-1:0]           dim_w
);

    localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int PW    = $clog2(MAXD);
    localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int LCW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int LW    = (DW > CFG_DATA_W) ? DW : CFG_DATA_W;
    localparam int RST_W = (DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET;
    localparam int RST_H = (DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET;

    function automatic logic [DW-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                                 input logic [LW-1:0] maxv);
        logic [LW-1:0] ve;
        logic [DW-1:0] res;
        ve = LW'(v);
        if (ve == '0) begin
            res = DW'(1);
        end else if (ve > maxv) begin
            res = DW'(maxv);
        end else begin
            res = DW'(ve);
        end
        return res;
    endfunction

    rot_t            rot_reg;
    logic [DW-1:0]   w_reg, h_reg;
    logic [LCW-1:0]  total_reg;
    logic [LCW-1:0]  load_count_reg, load_count_next;
    logic [PW-1:0]   col_reg, col_next, row_reg, row_next;

    logic [DW-1:0]   w_cfg, h_cfg;
    logic [2*DW-1:0] w_prod, h_prod;
    logic            accept, complete, swap, wrap, c_last, r_last, fin;
    logic [DW-1:0]   ow, oh, x_full, y_full;
    logic [PW-1:0]   c, r, x, y;
    fr90_ctl_t       ctl;

    assign w_cfg  = clamp_dim(cfg_wdata, LW'(MAX_WIDTH));
    assign h_cfg  = clamp_dim(cfg_wdata, LW'(MAX_HEIGHT));
    assign w_prod = w_cfg * h_reg;
    assign h_prod = w_reg * h_cfg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_reg   <= ROT_NONE;
            w_reg     <= DW'(RST_W);
            h_reg     <= DW'(RST_H);
            total_reg <= LCW'(RST_W * RST_H);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ROTATION: begin
                    rot_reg <= rot_t'(cfg_wdata[1:0]);
                end
                REG_WIDTH: begin
                    w_reg     <= w_cfg;
                    total_reg <= LCW'(w_prod);
                end
                REG_HEIGHT: begin
                    h_reg     <= h_cfg;
                    total_reg <= LCW'(h_prod);
                end
                default: begin
                end
            endcase
        end
    end

    assign dim_w    = w_reg;
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign complete = load_count_reg >= total_reg;
    assign swap     = (rot_reg == ROT_90) || (rot_reg == ROT_270);
    assign ow       = swap ? h_reg : w_reg;
    assign oh       = swap ? w_reg : h_reg;
    assign wrap     = (DW'(col_reg) >= ow) || (DW'(row_reg) >= oh);
    assign c        = wrap ? '0 : col_reg;
    assign r        = wrap ? '0 : row_reg;
    assign c_last   = DW'(c) == ow - DW'(1);
    assign r_last   = DW'(r) == oh - DW'(1);
    assign fin      = c_last && r_last;

    always_comb begin
        case (rot_reg)
            ROT_90: begin
                x_full = DW'(r);
                y_full = h_reg - DW'(c) - DW'(1);
            end
            ROT_180: begin
                x_full = w_reg - DW'(c) - DW'(1);
                y_full = h_reg - DW'(r) - DW'(1);
            end
            ROT_270: begin
                x_full = w_reg - DW'(r) - DW'(1);
                y_full = DW'(c);
            end
            default: begin
                x_full = DW'(c);
                y_full = DW'(r);
            end
        endcase
    end

    assign x = PW'(x_full);
    assign y = PW'(y_full);

    always_comb begin
        load_count_next = load_count_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        q_push          = 1'b0;
        ctl.op          = OP_WRITE;
        ctl.last        = 1'b0;
        if (accept) begin
            if (s_tuser == CMD_LOAD) begin
                if (!complete) begin
                    q_push          = 1'b1;
                    load_count_next = load_count_reg + LCW'(1);
                end
            end else if (!complete) begin
                q_push = 1'b1;
                ctl.op = OP_EARLY;
            end else begin
                q_push   = 1'b1;
                ctl.op   = OP_READ;
                ctl.last = fin;
                if (fin) begin
                    col_next        = '0;
                    row_next        = '0;
                    load_count_next = '0;
                end else if (c_last) begin
                    col_next = '0;
                    row_next = r + PW'(1);
                end else begin
                    col_next = c + PW'(1);
                    row_next = r;
                end
            end
        end
    end

    assign q_push_data = {ctl, s_tdata, load_count_reg[AW-1:0], y, x};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_count_reg <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
        end else begin
            load_count_reg <= load_count_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
        end
    end

endmodule

// ----- hdl/fr90_fifo.sv -----
// Short queue between the front and back parts of the frame rotation engine.
// Holds packed entries in a small register array; depends on fr90_pkg.
module fr90_fifo import fr90_pkg::*; #(
    parameter int WIDTH = 64,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hdl/fr90_back.sv -----
// Back part of the frame rotation engine: address multiply, frame store access and
// the output register of the result channel. Depends on fr90_pkg.
module fr90_back import fr90_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int DW         = 11,
    parameter int ENTRY_W    = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  logic [ENTRY_W-1:0] q_pop_data,
    output logic               q_pop,
    input  logic [DW-1:0]      dim_w,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [PIX_W-1:0]   m_tdata,
    output logic               m_tlast,
    output logic               m_tuser
);

    localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int PW    = $clog2(MAXD);
    localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int CTL_W = $bits(fr90_ctl_t);

    logic [PIX_W-1:0]   mem [DEPTH];

    logic [PW-1:0]      hx, hy;
    logic [AW-1:0]      hwaddr, haddr;
    logic [PIX_W-1:0]   hpix;
    fr90_ctl_t          hctl;
    logic [PW+DW-1:0]   prod;
    logic               advance;

    logic               s1_vld_reg, s2_vld_reg, m_vld_reg;
    fr90_ctl_t          s1_ctl_reg, s2_ctl_reg;
    logic [AW-1:0]      s1_addr_reg;
    logic [PIX_W-1:0]   s1_pix_reg, rd_data_reg, m_data_reg;
    logic               m_last_reg, m_user_reg;

    assign hx     = q_pop_data[PW-1:0];
    assign hy     = q_pop_data[2*PW-1:PW];
    assign hwaddr = q_pop_data[2*PW+AW-1:2*PW];
    assign hpix   = q_pop_data[2*PW+AW+PIX_W-1:2*PW+AW];
    assign hctl   = fr90_ctl_t'(q_pop_data[ENTRY_W-1:ENTRY_W-CTL_W]);
    assign prod   = hy * dim_w;
    assign haddr  = (hctl.op == OP_WRITE) ? hwaddr : AW'(prod + (PW+DW)'(hx));

    assign advance = !m_vld_reg || m_tready;
    assign q_pop   = advance && !q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
        end else if (advance) begin
            s1_vld_reg <= !q_empty;
            s2_vld_reg <= s1_vld_reg;
            m_vld_reg  <= s2_vld_reg && (s2_ctl_reg.op != OP_WRITE);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_ctl_reg  <= hctl;
            s1_addr_reg <= haddr;
            s1_pix_reg  <= hpix;
            s2_ctl_reg  <= s1_ctl_reg;
            m_data_reg  <= (s2_ctl_reg.op == OP_READ) ? rd_data_reg : '0;
            m_last_reg  <= (s2_ctl_reg.op == OP_READ) && s2_ctl_reg.last;
            m_user_reg  <= s2_ctl_reg.op == OP_EARLY;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s1_vld_reg) begin
            if (s1_ctl_reg.op == OP_WRITE) begin
                mem[s1_addr_reg] <= s1_pix_reg;
            end
            if (s1_ctl_reg.op == OP_READ) begin
                rd_data_reg <= mem[s1_addr_reg];
            end
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ----- hdl/fr90_checker.sv -----
// Port-level checker for the frame rotation engine, bound to the top level.
// Depends on fr90_pkg and frame_rotate_90_multiple_top.
module fr90_checker import fr90_pkg::*; (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_tready,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [PIX_W-1:0]        m_tdata,
    input logic                    m_tlast,
    input logic                    m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("Stalled result transfer changed.");

    a_early_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0 && !m_tlast)
        else $error("Early result carries a pixel or the last flag.");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("Block not idle after reset.");

endmodule

bind frame_rotate_90_multiple_top fr90_checker u_fr90_checker (.*);

// ----- test/testbench.sv -----
// Self-checking testbench for the frame rotation engine (0, 90, 180 and 270 degrees).
// A scoreboard class predicts every rotated pixel from the accepted transfers and the
// register settings; plain tasks drive the streams. Depends on fr90_pkg and the top level.
module testbench import fr90_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W        = DEF_MAX_WIDTH;
    localparam int MAX_H        = DEF_MAX_HEIGHT;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE       = 12;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 40;
    localparam int CALM_ITEMS   = 15;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             last;
        logic             early;
    } rotated_px_t;

    class rotation_checker;
        rot_t                 rot;
        logic [10:0]          width_reg;
        logic [10:0]          height_reg;
        logic [PIX_W-1:0]     frame_mem [int unsigned];
        int unsigned          loaded;
        int unsigned          col;
        int unsigned          row;
        rotated_px_t          pending_pixels [$];
        int                   failures;

        function new();
            rot        = ROT_NONE;
            width_reg  = 11'(DIM_RESET);
            height_reg = 11'(DIM_RESET);
            loaded     = 0;
            col        = 0;
            row        = 0;
            failures   = 0;
        endfunction

        function int unsigned clamp_dim(logic [10:0] v, int unsigned maxv);
            if (v == 0) return 1;
            if (v > maxv) return maxv;
            return v;
        endfunction

        function int unsigned frame_pixels();
            return clamp_dim(width_reg, MAX_W) * clamp_dim(height_reg, MAX_H);
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_ROTATION: rot = rot_t'(val[1:0]);
                REG_WIDTH:    width_reg = val;
                REG_HEIGHT:   height_reg = val;
                default:      ;
            endcase
        endfunction

        function void note_transfer(logic cmd, logic [PIX_W-1:0] pix);
            int unsigned w, h, total, ow, oh, x, y;
            rotated_px_t res;
            w = clamp_dim(width_reg, MAX_W);
            h = clamp_dim(height_reg, MAX_H);
            total = w * h;
            if (cmd == CMD_LOAD) begin
                if (loaded < total) begin
                    frame_mem[loaded] = pix;
                    loaded++;
                end
                return;
            end
            if (loaded < total) begin
                res.pixel = '0;
                res.last  = 1'b0;
                res.early = 1'b1;
                pending_pixels.push_back(res);
                return;
            end
            if (rot == ROT_90 || rot == ROT_270) begin
                ow = h;
                oh = w;
            end else begin
                ow = w;
                oh = h;
            end
            if (col >= ow || row >= oh) begin
                col = 0;
                row = 0;
            end
            case (rot)
                ROT_90: begin
                    x = row;
                    y = h - 1 - col;
                end
                ROT_180: begin
                    x = w - 1 - col;
                    y = h - 1 - row;
                end
                ROT_270: begin
                    x = w - 1 - row;
                    y = col;
                end
                default: begin
                    x = col;
                    y = row;
                end
            endcase
            res.pixel = frame_mem[y * w + x];
            res.last  = (col == ow - 1 && row == oh - 1);
            res.early = 1'b0;
            if (res.last) begin
                col = 0;
                row = 0;
                loaded = 0;
            end else if (col == ow - 1) begin
                col = 0;
                row++;
            end else begin
                col++;
            end
            pending_pixels.push_back(res);
        endfunction

        function void check_pixel(logic [PIX_W-1:0] pix, logic lst, logic erl);
            rotated_px_t want;
            if (pending_pixels.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("MISMATCH: unexpected transfer pixel=%h last=%b early=%b",
                             pix, lst, erl);
                return;
            end
            want = pending_pixels.pop_front();
            if (pix !== want.pixel || lst !== want.last || erl !== want.early) begin
                failures++;
                if (failures <= 10)
                    $display("MISMATCH: expected pixel=%h last=%b early=%b,",
                             " got pixel=%h last=%b early=%b",
                             want.pixel, want.last, want.early, pix, lst, erl);
            end
        endfunction

        function void close_out();
            if (pending_pixels.size() != 0) begin
                failures++;
                $display("MISMATCH: %0d expected pixels never arrived", pending_pixels.size());
            end
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [PIX_W-1:0]       s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [PIX_W-1:0]       m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    rotation_checker board = new();
    bit              idle_on = 1'b1;
    bit              long_hold_req = 1'b0;
    int              items_sent = 0;
    int              cycles = 0;

    always #4 aclk = ~aclk;

    frame_rotate_90_multiple_top #(
        .MAX_WIDTH (DEF_MAX_WIDTH),
        .MAX_HEIGHT(DEF_MAX_HEIGHT)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                board.check_pixel(m_tdata, m_tlast, m_tuser);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                hold_left = $urandom_range(0, 14);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [PIX_W-1:0] pix);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        board.note_transfer(cmd, pix);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (board.pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        board.write_reg(idx, val);
    endtask

    task automatic configure(input rot_t r, input logic [10:0] w, input logic [10:0] h);
        cfg_write(REG_ROTATION, CFG_DATA_W'(r));
        cfg_write(REG_WIDTH, w);
        cfg_write(REG_HEIGHT, h);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_frame(input int unsigned n_loads, input int unsigned n_emits);
        repeat (n_loads) send_item(CMD_LOAD, PIX_W'($urandom));
        repeat (n_emits) send_item(CMD_EMIT, PIX_W'($urandom));
    endtask

    initial begin
        int          start;
        int          kind;
        int unsigned total;
        logic [10:0] w, h;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset geometry is the full store, so these emits come too early.
        send_item(CMD_EMIT, 24'hFFFFFF);
        send_item(CMD_LOAD, 24'hFFFFFF);
        send_item(CMD_LOAD, 24'h000000);
        send_item(CMD_EMIT, 24'h000000);
        wait_idle();

        // Zero sizes mean one pixel, already loaded; after it is read, one load is kept, one drops.
        configure(ROT_90, 11'd0, 11'd0);
        send_item(CMD_EMIT, 24'h000000);
        send_item(CMD_LOAD, 24'h123456);
        send_item(CMD_LOAD, 24'hABCDEF);
        send_item(CMD_EMIT, 24'hFFFFFF);
        wait_idle();

        configure(ROT_270, 11'd3, 11'd2);
        for (int i = 0; i < 6; i++)
            send_item(CMD_LOAD, PIX_W'(24'h2A5A5A * (i + 1)) ^ {24{i[0]}});
        send_frame(0, 3);
        wait_idle();

        // Rotation changes in the middle of a read-out, then the shape changes with no frame loaded.
        configure(ROT_180, 11'd3, 11'd2);
        send_frame(0, 3);
        wait_idle();
        configure(ROT_NONE, 11'd2, 11'd3);
        send_frame(0, 2);
        wait_idle();

        // Long output stall while a whole frame is offered.
        configure(ROT_90, 11'd5, 11'd4);
        long_hold_req = 1'b1;
        send_frame(20, 20);
        wait_idle();

        // Largest sizes: oversize values saturate, reads reach the far end of the loaded frame.
        configure(ROT_180, 11'h7FF, 11'd1);
        send_frame(MAX_W, 5);
        wait_idle();
        configure(ROT_90, 11'd0, 11'h7FF);
        send_frame(0, 5);
        wait_idle();

        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            idle_on = (items_sent - start) < (RANDOM_ITEMS - CALM_ITEMS);
            w = ($urandom_range(0, 11) == 0) ? 11'd0 : 11'($urandom_range(1, 6));
            h = ($urandom_range(0, 11) == 0) ? 11'd0 : 11'($urandom_range(1, 6));
            configure(rot_t'($urandom_range(0, 3)), w, h);
            total = board.frame_pixels();
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                send_frame(total, total);
            end else if (kind <= 8) begin
                send_frame($urandom_range(0, total + 2), $urandom_range(0, total + 2));
            end else begin
                repeat ($urandom_range(1, 8))
                    send_item(logic'($urandom_range(0, 1)), PIX_W'($urandom));
            end
            wait_idle();
        end

        board.close_out();
        if (board.failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
hdl/fr90_pkg.sv
hdl/fr90_front.sv
hdl/fr90_fifo.sv
hdl/fr90_back.sv
hdl/frame_rotate_90_multiple_top.sv
hdl/fr90_checker.sv
test/testbench.sv
